// ===== sv/hdu_pkg.sv =====
package hdu_pkg;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int PERIOD_W  = 9;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 9'd96;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN       = 9'd2;

    localparam logic [3:0] START_INDEX     = 4'd0;
    localparam logic [3:0] FIRST_DATA_INDEX = 4'd1;
    localparam logic [3:0] LAST_DATA_INDEX = 4'd8;
    localparam logic [3:0] STOP_INDEX      = 4'd9;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RX   = 2'd1,
        MODE_TX   = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t               mode;
        logic [PERIOD_W-1:0] tick_count;
        logic [3:0]          bit_index;
        logic [7:0]          shift_byte;
        logic                line_out;
    } eng_state_t;

    // lowest bit last
    typedef struct packed {
        logic [7:0] send_byte;
        logic       send_request;
        logic       rx_level;
    } tick_in_t;

    typedef struct packed {
        logic       tx_done;
        logic       frame_error;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       busy_res;
        logic       tx_line;
    } tick_res_t;

    localparam int IN_W  = $bits(tick_in_t);
    localparam int RES_W = $bits(tick_res_t);

endpackage

// ===== sv/half_duplex_uart_8n1.sv =====
// Channel | Dir | tdata bits (low to high)
// s_      | in  | rx_level, send_request, send_byte[7:0], zero pad
// m_      | out | tx_line, busy_res, rx_valid, rx_byte[7:0], frame_error, tx_done, pad
// cfg_    | in  | bit_period[8:0], written when cfg_we is high
//
// One tick per transaction; one result transaction per tick, presented in the cycle after the tick is accepted.
// Ticks are taken every cycle while the result register is empty or being drained.
// The engine state and the result register update on the same edge.
// Reset: engine idle, tx line high, bit_period 96, no result pending.
// A stalled m_ side holds s_tready low; the engine only advances on accepted ticks.
module half_duplex_uart_8n1
    import hdu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // rx_level, send_request, send_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // tx_line, busy_res, rx_valid, rx_byte,
                                            // frame_error, tx_done
    input  logic                 cfg_we,
    input  logic [PERIOD_W-1:0]  cfg_wdata
);

    eng_state_t          state_reg;
    eng_state_t          state_next;
    logic [PERIOD_W-1:0] period_reg;
    tick_in_t            tin;
    tick_res_t           res;
    logic                room;
    logic                accept;

    assign tin      = tick_in_t'(s_tdata[IN_W-1:0]);
    assign s_tready = room;
    assign accept   = s_tvalid && room;

    hdu_step u_step (
        .cur        (state_reg),
        .tin        (tin),
        .bit_period (period_reg),
        .nxt        (state_next),
        .res        (res)
    );

    hdu_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode       <= MODE_IDLE;
            state_reg.tick_count <= '0;
            state_reg.bit_index  <= START_INDEX;
            state_reg.shift_byte <= '0;
            state_reg.line_out   <= 1'b1;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= BIT_PERIOD_RESET;
        end else if (cfg_we) begin
            period_reg <= cfg_wdata;
        end
    end

endmodule

// ===== sv/hdu_step.sv =====
module hdu_step
    import hdu_pkg::*;
(
    input  eng_state_t          cur,
    input  tick_in_t            tin,
    input  logic [PERIOD_W-1:0] bit_period,
    output eng_state_t          nxt,
    output tick_res_t           res
);

    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] tick_dec;
    logic [3:0]          idx_inc;
    logic                bit_event;

    always_comb begin
        period    = (bit_period < PERIOD_MIN) ? PERIOD_MIN : bit_period;
        tick_dec  = cur.tick_count - 9'd1;
        idx_inc   = cur.bit_index + 4'd1;
        bit_event = 1'b0;
        nxt       = cur;
        res       = '0;

        case (cur.mode)
            MODE_RX, MODE_TX: begin
                nxt.tick_count = tick_dec;
                if (tick_dec == '0) begin
                    bit_event      = 1'b1;
                    nxt.tick_count = period;
                end
            end
            default: ;
        endcase

        case (cur.mode)
            MODE_RX: begin
                if (bit_event) begin
                    if (cur.bit_index == START_INDEX) begin
                        if (!tin.rx_level) begin
                            nxt.shift_byte = '0;
                            nxt.bit_index  = FIRST_DATA_INDEX;
                        end else begin
                            nxt.mode = MODE_IDLE;
                        end
                    end else if (cur.bit_index <= LAST_DATA_INDEX) begin
                        nxt.shift_byte = {tin.rx_level, cur.shift_byte[7:1]};
                        nxt.bit_index  = idx_inc;
                    end else begin
                        if (tin.rx_level) begin
                            res.rx_valid = 1'b1;
                            res.rx_byte  = cur.shift_byte;
                        end else begin
                            res.frame_error = 1'b1;
                        end
                        nxt.bit_index = START_INDEX;
                        nxt.mode      = MODE_IDLE;
                    end
                end
            end
            MODE_TX: begin
                if (bit_event) begin
                    nxt.bit_index = idx_inc;
                    if (idx_inc inside {[FIRST_DATA_INDEX:LAST_DATA_INDEX]}) begin
                        nxt.line_out   = cur.shift_byte[0];
                        nxt.shift_byte = {1'b0, cur.shift_byte[7:1]};
                    end else if (idx_inc == STOP_INDEX) begin
                        nxt.line_out = 1'b1;
                    end else begin
                        nxt.line_out  = 1'b1;
                        res.tx_done   = 1'b1;
                        nxt.bit_index = START_INDEX;
                        nxt.mode      = MODE_IDLE;
                    end
                end
            end
            default: begin
                nxt.mode = MODE_IDLE;
                if (!tin.rx_level) begin
                    nxt.mode       = MODE_RX;
                    nxt.bit_index  = START_INDEX;
                    nxt.tick_count = {1'b0, period[PERIOD_W-1:1]};
                end else if (tin.send_request) begin
                    nxt.mode       = MODE_TX;
                    nxt.shift_byte = tin.send_byte;
                    nxt.bit_index  = START_INDEX;
                    nxt.line_out   = 1'b0;
                    nxt.tick_count = period;
                end
            end
        endcase

        res.tx_line  = nxt.line_out;
        res.busy_res = (nxt.mode != MODE_IDLE);
    end

endmodule

// ===== sv/hdu_out_reg.sv =====
module hdu_out_reg
    import hdu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  tick_res_t            res,
    output logic                 room,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic      valid_reg;
    logic      valid_next;
    tick_res_t data_reg;

    assign room       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, data_reg};

endmodule

// ===== test/tb.sv =====
module tb;
    import hdu_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_TICKS = 650;
    localparam logic [PERIOD_W-1:0] OPENING [6] = '{9'd2, 9'd1, 9'd0, 9'd3, 9'd5, 9'd8};

    typedef struct packed {
        logic                is_cfg;
        logic [PERIOD_W-1:0] period;
        tick_in_t            stim;
        logic [7:0]          reps;
        logic                fixed;
        tick_res_t           want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we;
    logic [PERIOD_W-1:0]  cfg_wdata;

    // shadow copy of the transceiver
    mode_t               eng_mode;
    logic [PERIOD_W-1:0] eng_ticks;
    logic [3:0]          eng_bit;
    logic [7:0]          eng_shift;
    logic                eng_line;
    logic [PERIOD_W-1:0] bit_period_r;

    tick_res_t pending_results [$];
    dir_row_t  dir_rows [14];

    int        cycle_no = 0;
    int        item_no = 0;
    int        phase_sent = 0;
    int        fail_count = 0;
    int        results_taken = 0;
    int        ready_hold = 0;
    int        ready_pick;
    bit        long_hold_done = 1'b0;
    tick_res_t seen_res;
    tick_res_t due_res;

    half_duplex_uart_8n1 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic tick_res_t advance_uart(input tick_in_t t);
        tick_res_t           r;
        logic                fire;
        logic [PERIOD_W-1:0] per;
        r = '0;
        fire = 1'b0;
        per = (bit_period_r < PERIOD_MIN) ? PERIOD_MIN : bit_period_r;
        if (eng_mode == MODE_RX || eng_mode == MODE_TX) begin
            eng_ticks = eng_ticks - 9'd1;
            if (eng_ticks == '0) begin
                fire = 1'b1;
                eng_ticks = per;
            end
        end
        case (eng_mode)
            MODE_RX: begin
                if (fire) begin
                    if (eng_bit == START_INDEX) begin
                        if (!t.rx_level) begin
                            eng_shift = '0;
                            eng_bit = FIRST_DATA_INDEX;
                        end else begin
                            eng_mode = MODE_IDLE;
                        end
                    end else if (eng_bit <= LAST_DATA_INDEX) begin
                        eng_shift = {t.rx_level, eng_shift[7:1]};
                        eng_bit = eng_bit + 4'd1;
                    end else begin
                        if (t.rx_level) begin
                            r.rx_valid = 1'b1;
                            r.rx_byte = eng_shift;
                        end else begin
                            r.frame_error = 1'b1;
                        end
                        eng_bit = START_INDEX;
                        eng_mode = MODE_IDLE;
                    end
                end
            end
            MODE_TX: begin
                if (fire) begin
                    eng_bit = eng_bit + 4'd1;
                    if (eng_bit >= FIRST_DATA_INDEX && eng_bit <= LAST_DATA_INDEX) begin
                        eng_line = eng_shift[0];
                        eng_shift = eng_shift >> 1;
                    end else if (eng_bit == STOP_INDEX) begin
                        eng_line = 1'b1;
                    end else begin
                        eng_line = 1'b1;
                        r.tx_done = 1'b1;
                        eng_bit = START_INDEX;
                        eng_mode = MODE_IDLE;
                    end
                end
            end
            default: begin
                eng_mode = MODE_IDLE;
                if (!t.rx_level) begin
                    eng_mode = MODE_RX;
                    eng_bit = START_INDEX;
                    eng_ticks = per >> 1;
                end else if (t.send_request) begin
                    eng_mode = MODE_TX;
                    eng_shift = t.send_byte;
                    eng_bit = START_INDEX;
                    eng_line = 1'b0;
                    eng_ticks = per;
                end
            end
        endcase
        r.tx_line = eng_line;
        r.busy_res = (eng_mode != MODE_IDLE);
        return r;
    endfunction

    function automatic tick_res_t outcome(input logic line, input logic busy, input logic valid,
                                          input logic [7:0] data, input logic ferr,
                                          input logic done);
        tick_res_t r;
        r.tx_line = line;
        r.busy_res = busy;
        r.rx_valid = valid;
        r.rx_byte = data;
        r.frame_error = ferr;
        r.tx_done = done;
        return r;
    endfunction

    function automatic dir_row_t tick_row(input logic rx, input logic req, input logic [7:0] data,
                                          input int reps, input logic fixed,
                                          input tick_res_t want);
        dir_row_t r;
        r = '0;
        r.stim.rx_level = rx;
        r.stim.send_request = req;
        r.stim.send_byte = data;
        r.reps = 8'(reps);
        r.fixed = fixed;
        r.want = want;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [PERIOD_W-1:0] per);
        dir_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.period = per;
        return r;
    endfunction

    task automatic send_tick(input tick_in_t t, input logic fixed, input tick_res_t want);
        int        gap;
        tick_res_t predicted;
        gap = 0;
        if (item_no % 256 >= 64) begin
            gap = $urandom_range(0, 99);
            gap = (gap < 70) ? 0 : (gap < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(t);
        do @(posedge aclk); while (s_tready !== 1'b1);
        predicted = advance_uart(t);
        pending_results.push_back(fixed ? want : predicted);
        item_no++;
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] per);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_wdata <= per;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        bit_period_r = per;
    endtask

    task automatic line_tick(input logic rx, input logic req);
        tick_in_t t;
        t.rx_level = rx;
        t.send_request = req;
        t.send_byte = 8'($urandom);
        send_tick(t, 1'b0, '0);
        phase_sent++;
    endtask

    task automatic run_phase(input logic [PERIOD_W-1:0] per, input int budget);
        int         eff;
        int         pick;
        int         k;
        int         b;
        int         span;
        logic       stop_bit;
        logic [9:0] frame;
        write_period(per);
        eff = int'((per < PERIOD_MIN) ? PERIOD_MIN : per);
        phase_sent = 0;
        while (phase_sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // well-formed frame, stop bit mostly good
                stop_bit = ($urandom_range(0, 7) != 0);
                frame = {stop_bit, 8'($urandom), 1'b0};
                span = $urandom_range(0, 3);
                for (k = 0; k < span && phase_sent < budget; k++)
                    line_tick(1'b1, 1'b0);
                for (b = 0; b < 10; b++)
                    for (k = 0; k < eff && phase_sent < budget; k++)
                        line_tick(frame[b], $urandom_range(0, 15) == 0);
            end else if (pick < 75) begin
                line_tick(1'b1, 1'b1);
                span = $urandom_range(eff * 5, eff * 10 + 2);
                for (k = 0; k < span && phase_sent < budget; k++)
                    line_tick($urandom_range(0, 15) != 0, $urandom_range(0, 7) == 0);
            end else if (pick < 85) begin
                // start pulse that is gone by the mid-bit sample
                span = $urandom_range(1, eff / 2);
                for (k = 0; k < span && phase_sent < budget; k++)
                    line_tick(1'b0, 1'b0);
                for (k = 0; k < eff && phase_sent < budget; k++)
                    line_tick(1'b1, 1'b0);
            end else begin
                span = $urandom_range(1, 8);
                for (k = 0; k < span && phase_sent < budget; k++)
                    line_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
                seen_res = tick_res_t'(m_tdata[RES_W-1:0]);
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("tb: unexpected result %h", seen_res);
                end else begin
                    due_res = pending_results.pop_front();
                    if (seen_res !== due_res) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("tb: #%0d want tx=%b bsy=%b v=%b d=%h fe=%b dn=%b",
                                     results_taken,
                                     due_res.tx_line, due_res.busy_res, due_res.rx_valid,
                                     due_res.rx_byte, due_res.frame_error, due_res.tx_done);
                            $display("tb: #%0d got  tx=%b bsy=%b v=%b d=%h fe=%b dn=%b",
                                     results_taken,
                                     seen_res.tx_line, seen_res.busy_res, seen_res.rx_valid,
                                     seen_res.rx_byte, seen_res.frame_error, seen_res.tx_done);
                        end
                    end
                end
                results_taken++;
            end
            // one long back-pressure stretch to fill the block
            if (results_taken >= 300 && !long_hold_done) begin
                long_hold_done = 1'b1;
                ready_hold = 400;
            end
            if (ready_hold > 0) begin
                ready_hold--;
                m_tready <= 1'b0;
            end else if (cycle_no % 512 < 128) begin
                m_tready <= 1'b1;
            end else begin
                ready_pick = $urandom_range(0, 99);
                if (ready_pick < 75) begin
                    m_tready <= 1'b1;
                end else begin
                    ready_hold = (ready_pick < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    initial begin
        int ph;
        int budget;
        int random_ticks;
        eng_mode = MODE_IDLE;
        eng_ticks = '0;
        eng_bit = START_INDEX;
        eng_shift = '0;
        eng_line = 1'b1;
        bit_period_r = BIT_PERIOD_RESET;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        dir_rows = '{
            tick_row(1'b1, 1'b0, 8'h00,  1, 1'b1, outcome(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0)),
            cfg_row(9'd0),
            // receive start wins over a send request
            tick_row(1'b0, 1'b1, 8'hFF,  1, 1'b1, outcome(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)),
            // start bit high at its sample: silent drop
            tick_row(1'b1, 1'b0, 8'h00,  1, 1'b1, outcome(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0)),
            tick_row(1'b1, 1'b1, 8'hFF,  1, 1'b1, outcome(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)),
            tick_row(1'b0, 1'b1, 8'h00, 19, 1'b0, '0),
            tick_row(1'b1, 1'b0, 8'h00,  1, 1'b1, outcome(1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1)),
            cfg_row(9'd1),
            tick_row(1'b0, 1'b0, 8'hAA,  2, 1'b0, '0),
            tick_row(1'b1, 1'b0, 8'h55, 17, 1'b0, '0),
            tick_row(1'b1, 1'b0, 8'h00,  1, 1'b1, outcome(1'b1, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0)),
            tick_row(1'b0, 1'b0, 8'h00, 19, 1'b0, '0),
            tick_row(1'b0, 1'b0, 8'h00,  1, 1'b1, outcome(1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0)),
            tick_row(1'b1, 1'b1, 8'h00,  1, 1'b0, '0)
        };
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                write_period(dir_rows[i].period);
            else
                repeat (dir_rows[i].reps)
                    send_tick(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);
        end

        ph = 0;
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS) begin
            budget = $urandom_range(120, 200);
            run_phase((ph < 6) ? OPENING[ph] : PERIOD_W'($urandom_range(2, 12)), budget);
            random_ticks += budget;
            ph++;
        end
        run_phase(9'd256, 300);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
